// ===== design/imh_pkg.sv =====
// Shared types and codes for the indexed max-heap core.
package imh_pkg;

  localparam int ID_W    = 10;
  localparam int GAIN_W  = 16;
  localparam int CNT_W   = 11;
  localparam int LIMIT_W = 11;

  localparam logic [LIMIT_W-1:0] CELL_LIMIT_RST = 11'd1024;
  localparam logic signed [GAIN_W-1:0] GAIN_EMPTY = 16'sh8000;

  typedef enum logic [2:0] {
    MODE_INSERT  = 3'd0,
    MODE_EXTRACT = 3'd1,
    MODE_PEEK    = 3'd2,
    MODE_REMOVE  = 3'd3,
    MODE_CHANGE  = 3'd4,
    MODE_CLEAR   = 3'd5
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_ABSENT = 2'd1,
    ST_FULL   = 2'd2,
    ST_BADID  = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_DECODE,
    S_MAP,
    S_ROOT,
    S_LAST,
    S_CHG,
    S_UP_ISSUE,
    S_UP_CMP,
    S_DN_ISSUE,
    S_DN_L,
    S_DN_R,
    S_PLACE,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [2:0]               mode;
    logic [ID_W-1:0]          cell_id;
    logic signed [GAIN_W-1:0] gain;
  } req_t;

  typedef struct packed {
    logic [ID_W-1:0]          out_id;
    logic signed [GAIN_W-1:0] out_gain;
    logic [1:0]               status;
    logic [CNT_W-1:0]         count;
  } rsp_t;

endpackage

// ===== design/indexed_max_heap_core.sv =====
// Indexed binary max-heap of (cell id, gain) entries with an id-to-slot position map.
//
// Each request transfer carries one operation (insert, extract max, peek max, remove by id,
// add a signed delta to an id's gain, clear) and yields exactly one response transfer.
// The heap lives in a MAX_CELLS-deep synchronous memory of (id, gain) entries and the
// position map in a second synchronous memory of (present, slot) per id; both have one
// write port and one read port with registered read data. The moving entry is held
// in a register while it sifts ("hole" sift): each level up reads the parent, then
// compares and moves it down; each level down reads the left child, reads the right
// child, then compares and moves the larger one up; and the entry is written once at its
// final slot. Clear sweeps the whole position map one entry per cycle, and the same
// sweep runs after reset, during which no request is taken (cfg writes still land).
// One operation is in flight at a time; a finished response waits in its output
// register while the next request is accepted and worked on. Gains are saturated to
// GAIN_BITS signed; equal gains never swap, so ties keep their slots.
module indexed_max_heap_core
  import imh_pkg::*;
#(
  parameter int MAX_CELLS = 1024,
  parameter int GAIN_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_ready,
  input  req_t               req,
  output logic               rsp_valid,
  input  logic               rsp_ready,
  output rsp_t               rsp,
  input  logic               cfg_we,
  input  logic [LIMIT_W-1:0] cfg_wdata
);

  localparam int HEAP_AW   = (MAX_CELLS > 2) ? $clog2(MAX_CELLS) : 1;
  localparam int MAP_DEPTH = (MAX_CELLS < (1 << ID_W)) ? MAX_CELLS : (1 << ID_W);
  localparam int MAP_AW    = (MAP_DEPTH > 2) ? $clog2(MAP_DEPTH) : 1;
  localparam int HCNT_W    = $clog2(MAX_CELLS + 1);
  localparam int IX_W      = HEAP_AW + 2;
  localparam int SUM_W     = ((GAIN_BITS > GAIN_W) ? GAIN_BITS : GAIN_W) + 1;

  typedef struct packed {
    logic [ID_W-1:0]             id;
    logic signed [GAIN_BITS-1:0] gain;
  } hent_t;

  typedef struct packed {
    logic               present;
    logic [HEAP_AW-1:0] slot;
  } ment_t;

  // Clamp a wide sum into the stored gain range.
  function automatic logic signed [GAIN_BITS-1:0] sat_gain(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] hi;
    logic signed [SUM_W-1:0] lo;
    hi = {{(SUM_W-GAIN_BITS+1){1'b0}}, {(GAIN_BITS-1){1'b1}}};
    lo = {{(SUM_W-GAIN_BITS+1){1'b1}}, {(GAIN_BITS-1){1'b0}}};
    if (v > hi) begin
      return hi[GAIN_BITS-1:0];
    end else if (v < lo) begin
      return lo[GAIN_BITS-1:0];
    end
    return v[GAIN_BITS-1:0];
  endfunction

  // Control state.
  state_t              state, state_next;
  logic [HCNT_W-1:0]   cnt, cnt_next;
  logic [MAP_AW-1:0]   clr_addr, clr_addr_next;
  logic                clr_op, clr_op_next;
  logic                rsp_valid_next;
  logic [LIMIT_W-1:0]  cell_limit;

  // Operation payload.
  req_t                op, op_next;
  logic [HEAP_AW-1:0]  slot, slot_next;
  hent_t               cur, cur_next;
  hent_t               lent, lent_next;
  logic                up_first, up_first_next;
  rsp_t                res, res_next;
  rsp_t                rsp_next;

  // Memories.
  hent_t               heap_mem [MAX_CELLS];
  ment_t               map_mem  [MAP_DEPTH];
  hent_t               hq;
  ment_t               mq;
  logic                heap_we;
  logic [HEAP_AW-1:0]  heap_waddr;
  hent_t               heap_wdata;
  logic [HEAP_AW-1:0]  heap_raddr;
  logic                map_we;
  logic [MAP_AW-1:0]   map_waddr;
  ment_t               map_wdata;
  logic [MAP_AW-1:0]   map_raddr;

  // Shared decode.
  logic                id_ok;
  logic                heap_full;
  logic [HEAP_AW-1:0]  last_slot;
  logic                s_lt_last;
  logic [HEAP_AW-1:0]  par;
  logic                up_win;
  logic [IX_W-1:0]     l_ix;
  logic [IX_W-1:0]     r_ix;
  logic                l_in;
  logic                r_in;
  logic                take_l;
  logic                take_r;
  logic signed [GAIN_BITS-1:0] best;
  logic                dn_move;
  hent_t               child;
  logic [HEAP_AW-1:0]  child_slot;
  logic                rsp_free;

  assign req_ready = (state == S_IDLE);
  assign rsp_free  = !rsp_valid || rsp_ready;

  assign id_ok     = (32'(op.cell_id) < 32'(cell_limit)) && (32'(op.cell_id) < MAX_CELLS);
  assign heap_full = 32'(cnt) >= MAX_CELLS;
  assign last_slot = HEAP_AW'(cnt - 1'b1);
  assign s_lt_last = (32'(mq.slot) + 32'd1) < 32'(cnt);
  assign par       = HEAP_AW'((slot - 1'b1) >> 1);
  assign up_win    = cur.gain > hq.gain;
  assign l_ix      = IX_W'({slot, 1'b1});
  assign r_ix      = l_ix + 1'b1;
  assign l_in      = 32'(l_ix) < 32'(cnt);
  assign r_in      = 32'(r_ix) < 32'(cnt);
  assign take_l    = lent.gain > cur.gain;
  assign best      = take_l ? lent.gain : cur.gain;
  assign take_r    = r_in && (hq.gain > best);
  assign dn_move   = take_l || take_r;
  assign child     = take_r ? hq : lent;
  assign child_slot = take_r ? HEAP_AW'(r_ix) : HEAP_AW'(l_ix);

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: begin
        if (clr_addr == MAP_AW'(MAP_DEPTH - 1)) begin
          state_next = clr_op ? S_DONE : S_IDLE;
        end
      end
      S_IDLE: begin
        if (req_valid) begin
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        case (op.mode)
          MODE_INSERT: state_next = (!id_ok || heap_full) ? S_DONE : S_MAP;
          MODE_REMOVE, MODE_CHANGE: state_next = id_ok ? S_MAP : S_DONE;
          MODE_EXTRACT, MODE_PEEK: state_next = (cnt == '0) ? S_DONE : S_ROOT;
          MODE_CLEAR: state_next = S_CLEAR;
          default: state_next = S_DONE;
        endcase
      end
      S_MAP: begin
        if (op.mode == MODE_INSERT) begin
          state_next = mq.present ? S_DONE : S_UP_ISSUE;
        end else if (!mq.present) begin
          state_next = S_DONE;
        end else if (op.mode == MODE_REMOVE) begin
          state_next = s_lt_last ? S_LAST : S_DONE;
        end else begin
          state_next = S_CHG;
        end
      end
      S_ROOT: begin
        if (op.mode == MODE_EXTRACT && cnt > HCNT_W'(1)) begin
          state_next = S_LAST;
        end else begin
          state_next = S_DONE;
        end
      end
      S_LAST: state_next = (op.mode == MODE_EXTRACT) ? S_DN_ISSUE : S_UP_ISSUE;
      S_CHG: state_next = (op.gain > 16'sd0) ? S_UP_ISSUE : S_DN_ISSUE;
      S_UP_ISSUE: begin
        if (slot == '0) begin
          state_next = up_first ? S_DN_ISSUE : S_PLACE;
        end else begin
          state_next = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        if (up_win) begin
          state_next = S_UP_ISSUE;
        end else begin
          state_next = up_first ? S_DN_ISSUE : S_PLACE;
        end
      end
      S_DN_ISSUE: state_next = l_in ? S_DN_L : S_PLACE;
      S_DN_L: state_next = S_DN_R;
      S_DN_R: state_next = dn_move ? S_DN_ISSUE : S_PLACE;
      S_PLACE: state_next = S_DONE;
      S_DONE: begin
        if (rsp_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Datapath and memory controls.
  always_comb begin
    op_next        = op;
    cnt_next       = cnt;
    clr_addr_next  = clr_addr;
    clr_op_next    = clr_op;
    slot_next      = slot;
    cur_next       = cur;
    lent_next      = lent;
    up_first_next  = up_first;
    res_next       = res;
    rsp_next       = rsp;
    rsp_valid_next = rsp_valid && !rsp_ready;
    heap_we        = 1'b0;
    heap_waddr     = slot;
    heap_wdata     = cur;
    heap_raddr     = '0;
    map_we         = 1'b0;
    map_waddr      = MAP_AW'(cur.id);
    map_wdata      = '{present: 1'b1, slot: slot};
    map_raddr      = MAP_AW'(op.cell_id);
    case (state)
      S_CLEAR: begin
        map_we        = 1'b1;
        map_waddr     = clr_addr;
        map_wdata     = '0;
        clr_addr_next = clr_addr + 1'b1;
      end
      S_IDLE: begin
        if (req_valid) begin
          op_next  = req;
          res_next = '0;
        end
      end
      S_DECODE: begin
        case (op.mode)
          MODE_INSERT: begin
            if (!id_ok) begin
              res_next.status = ST_BADID;
            end else if (heap_full) begin
              res_next.status = ST_FULL;
            end
          end
          MODE_REMOVE, MODE_CHANGE: begin
            if (!id_ok) begin
              res_next.status = ST_BADID;
            end
          end
          MODE_EXTRACT, MODE_PEEK: begin
            if (cnt == '0) begin
              res_next.status   = ST_ABSENT;
              res_next.out_gain = GAIN_EMPTY;
            end
          end
          MODE_CLEAR: begin
            clr_addr_next = '0;
            clr_op_next   = 1'b1;
            cnt_next      = '0;
          end
          default: ;
        endcase
      end
      S_MAP: begin
        if (op.mode == MODE_INSERT) begin
          if (mq.present) begin
            res_next.status = ST_BADID;
          end else begin
            cur_next      = '{id: op.cell_id, gain: sat_gain(SUM_W'(op.gain))};
            slot_next     = HEAP_AW'(cnt);
            cnt_next      = cnt + 1'b1;
            up_first_next = 1'b0;
          end
        end else if (!mq.present) begin
          res_next.status = ST_ABSENT;
        end else if (op.mode == MODE_REMOVE) begin
          map_we        = 1'b1;
          map_waddr     = MAP_AW'(op.cell_id);
          map_wdata     = '0;
          cnt_next      = cnt - 1'b1;
          slot_next     = mq.slot;
          up_first_next = 1'b1;
          heap_raddr    = last_slot;
        end else begin
          slot_next     = mq.slot;
          up_first_next = 1'b0;
          heap_raddr    = mq.slot;
        end
      end
      S_ROOT: begin
        res_next.out_id   = hq.id;
        res_next.out_gain = GAIN_W'(hq.gain);
        if (op.mode == MODE_EXTRACT) begin
          map_we        = 1'b1;
          map_waddr     = MAP_AW'(hq.id);
          map_wdata     = '0;
          cnt_next      = cnt - 1'b1;
          slot_next     = '0;
          up_first_next = 1'b0;
          heap_raddr    = last_slot;
        end
      end
      S_LAST: cur_next = hq;
      S_CHG: begin
        cur_next = '{id: hq.id, gain: sat_gain(SUM_W'(hq.gain) + SUM_W'(op.gain))};
      end
      S_UP_ISSUE: heap_raddr = par;
      S_UP_CMP: begin
        if (up_win) begin
          // Move the parent down into the hole.
          heap_we       = 1'b1;
          heap_wdata    = hq;
          map_we        = 1'b1;
          map_waddr     = MAP_AW'(hq.id);
          slot_next     = par;
          up_first_next = 1'b0;
        end
      end
      S_DN_ISSUE: heap_raddr = HEAP_AW'(l_ix);
      S_DN_L: begin
        lent_next  = hq;
        heap_raddr = HEAP_AW'(r_ix);
      end
      S_DN_R: begin
        if (dn_move) begin
          // Move the larger child up into the hole.
          heap_we    = 1'b1;
          heap_wdata = child;
          map_we     = 1'b1;
          map_waddr  = MAP_AW'(child.id);
          slot_next  = child_slot;
        end
      end
      S_PLACE: begin
        heap_we = 1'b1;
        map_we  = 1'b1;
      end
      S_DONE: begin
        if (rsp_free) begin
          rsp_valid_next = 1'b1;
          rsp_next       = res;
          rsp_next.count = CNT_W'(cnt);
          clr_op_next    = 1'b0;
        end
      end
      default: ;
    endcase
  end

  // Heap and map memories, read data registered.
  always_ff @(posedge clk) begin
    if (heap_we) begin
      heap_mem[heap_waddr] <= heap_wdata;
    end
    hq <= heap_mem[heap_raddr];
  end

  always_ff @(posedge clk) begin
    if (map_we) begin
      map_mem[map_waddr] <= map_wdata;
    end
    mq <= map_mem[map_raddr];
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      cnt       <= '0;
      clr_addr  <= '0;
      clr_op    <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      cnt       <= cnt_next;
      clr_addr  <= clr_addr_next;
      clr_op    <= clr_op_next;
      rsp_valid <= rsp_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cell_limit <= CELL_LIMIT_RST;
    end else if (cfg_we) begin
      cell_limit <= cfg_wdata;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    op       <= op_next;
    slot     <= slot_next;
    cur      <= cur_next;
    lent     <= lent_next;
    up_first <= up_first_next;
    res      <= res_next;
    rsp      <= rsp_next;
  end

  // Entry count never passes the heap depth.
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    32'(cnt) <= MAX_CELLS)
    else $error("heap count above depth");

  // The hole always lies inside the live part of the heap while sifting.
  a_hole_live: assert property (@(posedge clk) disable iff (rst)
    (state == S_UP_ISSUE || state == S_DN_ISSUE) |-> (32'(slot) < 32'(cnt)))
    else $error("sift hole outside heap");

  // A parent compare never runs at the root.
  a_up_not_root: assert property (@(posedge clk) disable iff (rst)
    (state == S_UP_CMP) |-> (slot != '0))
    else $error("sift up compare at root");

  // A response appears only out of the completion state.
  a_rsp_src: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(state == S_DONE))
    else $error("response raised outside completion");

endmodule
